/* rtl/core/skvt_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the sorted key/value table.
package skvt_pkg;

  localparam int unsigned CapacityDflt = 32;
  localparam int unsigned MaxResults   = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [2:0] STATUS_INSERTED  = 3'd0;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
  localparam logic [2:0] STATUS_REMOVED   = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;
  localparam logic [2:0] STATUS_ENTRY     = 3'd5;
  localparam logic [2:0] STATUS_EMPTY     = 3'd6;

  localparam logic [1:0] SCAN_SEARCH = 2'd0;
  localparam logic [1:0] SCAN_UP     = 2'd1;
  localparam logic [1:0] SCAN_DOWN   = 2'd2;
  localparam logic [1:0] SCAN_LIST   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic [1:0] scan_mode;
    logic       write_new;
    logic       dec_count;
    logic       resp_en;
    logic [2:0] resp_status;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic key_eq;
    logic full;
    logic empty;
    logic pos_at_end;
    logic pos_is_last;
  } dp_stat_t;

endpackage

/* rtl/core/skvt_ctrl.sv */
// Operation sequencer for the sorted key/value table.
module skvt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         operation_i,
  input  skvt_pkg::dp_stat_t stat_i,
  output skvt_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);
  import skvt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_LIST   = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] op_q, op_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d       = operation_i;
          cmd_o.load = 1'b1;
          unique case (operation_i) inside
            OP_INSERT, OP_REMOVE: begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_mode  = SCAN_SEARCH;
              state_d          = S_SEARCH;
            end
            OP_LIST: begin
              if (stat_i.empty) begin
                cmd_o.resp_en     = 1'b1;
                cmd_o.resp_status = STATUS_EMPTY;
              end else begin
                cmd_o.scan_start = 1'b1;
                cmd_o.scan_mode  = SCAN_LIST;
                state_d          = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (!stat_i.scan_busy) begin
          state_d = S_IDLE;
          if (op_q == OP_INSERT) begin
            if (stat_i.key_eq) begin
              cmd_o.resp_en     = 1'b1;
              cmd_o.resp_status = STATUS_DUPLICATE;
            end else if (stat_i.full) begin
              cmd_o.resp_en     = 1'b1;
              cmd_o.resp_status = STATUS_FULL;
            end else if (stat_i.pos_at_end) begin
              cmd_o.write_new   = 1'b1;
              cmd_o.resp_en     = 1'b1;
              cmd_o.resp_status = STATUS_INSERTED;
            end else begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_mode  = SCAN_UP;
              state_d          = S_SHIFT;
            end
          end else begin
            if (!stat_i.key_eq) begin
              cmd_o.resp_en     = 1'b1;
              cmd_o.resp_status = STATUS_NOT_FOUND;
            end else if (stat_i.pos_is_last) begin
              cmd_o.dec_count   = 1'b1;
              cmd_o.resp_en     = 1'b1;
              cmd_o.resp_status = STATUS_REMOVED;
            end else begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_mode  = SCAN_DOWN;
              state_d          = S_SHIFT;
            end
          end
        end
      end
      S_SHIFT: begin
        if (!stat_i.scan_busy) begin
          state_d       = S_IDLE;
          cmd_o.resp_en = 1'b1;
          if (op_q == OP_INSERT) begin
            cmd_o.write_new   = 1'b1;
            cmd_o.resp_status = STATUS_INSERTED;
          end else begin
            cmd_o.dec_count   = 1'b1;
            cmd_o.resp_status = STATUS_REMOVED;
          end
        end
      end
      S_LIST: begin
        if (!stat_i.scan_busy) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* rtl/core/skvt_dp.sv */
// Table storage, scan pointer, compare and result registers for the sorted key/value table.
module skvt_dp #(
  parameter int unsigned CAPACITY = skvt_pkg::CapacityDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skvt_pkg::dp_cmd_t  cmd_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] item_value_i,
  output skvt_pkg::dp_stat_t stat_o,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic               last_o
);
  import skvt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [31:0] key_mem_q [CAPACITY];
  logic signed [31:0] val_mem_q [CAPACITY];

  logic signed [31:0] key_q, val_q;
  logic signed [31:0] key_rd_q, val_rd_q;
  logic [CW-1:0]      count_q, ptr_q, final_q, rd_idx_q, pos_q;
  logic [1:0]         mode_q;
  logic               iss_q, rd_vld_q, hit_q, eq_q;
  logic               out_valid_q, last_q;
  logic [2:0]         status_q;
  logic signed [31:0] value_q;

  logic [CW-1:0] list_n, first, fin;
  logic          start_ok, hit, list_emit;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic signed [31:0] wr_key, wr_val;

  assign list_n = (int'(count_q) > int'(MaxResults)) ? CW'(MaxResults) : count_q;
  assign hit    = rd_vld_q && (mode_q == SCAN_SEARCH) && !hit_q && (key_rd_q >= key_q);
  assign list_emit = rd_vld_q && (mode_q == SCAN_LIST);

  always_comb begin
    first    = '0;
    fin      = '0;
    start_ok = 1'b1;
    unique case (cmd_i.scan_mode)
      SCAN_SEARCH: begin
        fin      = count_q - CW'(1);
        start_ok = (count_q != '0);
      end
      SCAN_UP: begin
        first = count_q - CW'(1);
        fin   = pos_q;
      end
      SCAN_DOWN: begin
        first = pos_q + CW'(1);
        fin   = count_q - CW'(1);
      end
      SCAN_LIST: begin
        fin = list_n - CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = rd_idx_q[IW-1:0];
    wr_key = key_rd_q;
    wr_val = val_rd_q;
    if (cmd_i.write_new) begin
      wr_en  = 1'b1;
      wr_idx = pos_q[IW-1:0];
      wr_key = key_q;
      wr_val = val_q;
    end else if (rd_vld_q && (mode_q == SCAN_UP)) begin
      wr_en  = 1'b1;
      wr_idx = rd_idx_q[IW-1:0] + IW'(1);
    end else if (rd_vld_q && (mode_q == SCAN_DOWN)) begin
      wr_en  = 1'b1;
      wr_idx = rd_idx_q[IW-1:0] - IW'(1);
    end
  end

  // storage: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem_q[wr_idx] <= wr_key;
      val_mem_q[wr_idx] <= wr_val;
    end
    if (iss_q) begin
      key_rd_q <= key_mem_q[ptr_q[IW-1:0]];
      val_rd_q <= val_mem_q[ptr_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      iss_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      mode_q      <= SCAN_SEARCH;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q    <= iss_q;
      out_valid_q <= list_emit || cmd_i.resp_en;
      if (cmd_i.scan_start) begin
        iss_q  <= start_ok;
        mode_q <= cmd_i.scan_mode;
        hit_q  <= 1'b0;
      end else begin
        if (iss_q && ((ptr_q == final_q) || hit)) begin
          iss_q <= 1'b0;
        end
        if (hit) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.write_new) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.dec_count) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q;
    if (cmd_i.load) begin
      key_q <= key_i;
      val_q <= item_value_i;
    end
    if (cmd_i.scan_start) begin
      ptr_q   <= first;
      final_q <= fin;
    end else if (iss_q) begin
      ptr_q <= (mode_q == SCAN_UP) ? ptr_q - CW'(1) : ptr_q + CW'(1);
    end
    if (cmd_i.scan_start && (cmd_i.scan_mode == SCAN_SEARCH)) begin
      pos_q <= count_q;
      eq_q  <= 1'b0;
    end else if (hit) begin
      pos_q <= rd_idx_q;
      eq_q  <= (key_rd_q == key_q);
    end
    if (list_emit) begin
      status_q <= STATUS_ENTRY;
      value_q  <= val_rd_q;
      last_q   <= (rd_idx_q == final_q);
    end else begin
      status_q <= cmd_i.resp_status;
      value_q  <= '0;
      last_q   <= 1'b1;
    end
  end

  assign stat_o.scan_busy   = iss_q || rd_vld_q;
  assign stat_o.key_eq      = eq_q;
  assign stat_o.full        = (count_q == CW'(CAPACITY));
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.pos_at_end  = (pos_q == count_q);
  assign stat_o.pos_is_last = ((pos_q + CW'(1)) == count_q);

  assign result_valid_o = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = value_q;
  assign last_o         = last_q;

endmodule

/* rtl/core/sorted_key_value_table_top.sv */
// Sorted key/value table: ordered insert, remove and in-order listing over N = CAPACITY entries.
// Insert/remove: a pipelined search, then, where needed, a shift of the entries
// through the storage; one registered result follows completion.
// List: n results (at most MaxResults) on consecutive cycles after the command transfer.
// One command at a time while busy_o is high; results are strobed and cannot be stalled.
// Reset clears the entry count and control state only; storage needs no clearing.
module sorted_key_value_table_top #(
  parameter int unsigned CAPACITY = skvt_pkg::CapacityDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] item_value_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic               last_o
);
  import skvt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  skvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  skvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .key_i          (key_i),
    .item_value_i   (item_value_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .last_o         (last_o)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sorted key/value table: queued commands, strobed result checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skvt_pkg::*;

  localparam int unsigned Capacity   = CapacityDflt;
  localparam int unsigned KeyPool    = 44;
  localparam int unsigned RandItems  = 380;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned TailCycles = 100;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
    bit                 drain;
  } table_cmd_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic               last;
  } table_resp_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start_i      = 1'b0;
  logic [1:0]         operation_i  = OP_INSERT;
  logic signed [31:0] key_i        = '0;
  logic signed [31:0] item_value_i = '0;
  logic               busy_o;
  logic               result_valid_o;
  logic [2:0]         status_o;
  logic signed [31:0] out_value_o;
  logic               last_o;

  sorted_key_value_table_top #(
    .CAPACITY(Capacity)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .item_value_i  (item_value_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .last_o        (last_o)
  );

  table_cmd_t         pending_cmds[$];
  table_resp_t        expected_results[$];
  logic signed [31:0] shadow_keys  [Capacity];
  logic signed [31:0] shadow_values[Capacity];
  int unsigned        shadow_count = 0;
  logic signed [31:0] key_pool[KeyPool];
  int unsigned        errors       = 0;
  int unsigned        cycle_count  = 0;
  bit                 xfer         = 1'b0;
  int unsigned        burst_left   = 0;
  int unsigned        gap_left     = 0;
  table_cmd_t         cmd;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic push_resp(input logic [2:0] status, input logic signed [31:0] value,
                           input logic last);
    table_resp_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_table_op(input logic [1:0] op, input logic signed [31:0] k,
                                  input logic signed [31:0] v);
    int unsigned pos;
    int unsigned n;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < k) pos++;
    case (op)
      OP_INSERT: begin
        if (pos < shadow_count && shadow_keys[pos] == k) begin
          push_resp(STATUS_DUPLICATE, '0, 1'b1);
        end else if (shadow_count >= Capacity) begin
          push_resp(STATUS_FULL, '0, 1'b1);
        end else begin
          for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_keys[i]   = shadow_keys[i-1];
            shadow_values[i] = shadow_values[i-1];
          end
          shadow_keys[pos]   = k;
          shadow_values[pos] = v;
          shadow_count++;
          push_resp(STATUS_INSERTED, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_count && shadow_keys[pos] == k) begin
          for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i]   = shadow_keys[i+1];
            shadow_values[i] = shadow_values[i+1];
          end
          shadow_count--;
          push_resp(STATUS_REMOVED, '0, 1'b1);
        end else begin
          push_resp(STATUS_NOT_FOUND, '0, 1'b1);
        end
      end
      OP_LIST: begin
        if (shadow_count == 0) begin
          push_resp(STATUS_EMPTY, '0, 1'b1);
        end else begin
          n = (shadow_count < MaxResults) ? shadow_count : MaxResults;
          for (int unsigned i = 0; i < n; i++) begin
            push_resp(STATUS_ENTRY, shadow_values[i], (i + 1 == n));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_cmd(input logic [1:0] op, input logic signed [31:0] k,
                           input logic signed [31:0] v, input bit drain);
    table_cmd_t c;
    c.op    = op;
    c.key   = k;
    c.value = v;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  // Driver: fields change on the falling edge only
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !xfer) begin
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() == 0) begin
        start_i <= 1'b0;
      end else if (pending_cmds[0].drain && expected_results.size() != 0) begin
        start_i <= 1'b0;
      end else begin
        cmd = pending_cmds.pop_front();
        operation_i  <= cmd.op;
        key_i        <= cmd.key;
        item_value_i <= cmd.value;
        start_i      <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 45);
        end
      end
    end
  end

  // Monitor and predictor: sampled on the rising edge
  always @(posedge clk_i) begin
    table_resp_t e;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("sorted_key_value_table_top verification failed");
      $finish;
    end else if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d value %h last %b",
                                    status_o, out_value_o, last_o));
        end else begin
          e = expected_results.pop_front();
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
          if (out_value_o !== e.value)
            report_mismatch($sformatf("value %h, want %h", out_value_o, e.value));
          if (last_o !== e.last)
            report_mismatch($sformatf("last %b, want %b", last_o, e.last));
        end
      end
      xfer = start_i && !busy_o;
      if (xfer) predict_table_op(operation_i, key_i, item_value_i);
    end else begin
      xfer = 1'b0;
    end
  end

  initial begin
    int unsigned r;
    int unsigned phase;
    logic [1:0]  op;
    logic signed [31:0] k;

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = 32'shFFFF_FFFF;
    for (int unsigned i = 4; i < KeyPool; i++) key_pool[i] = $urandom;

    // directed: empty table, extremes, duplicate, ordering, ignored code
    queue_cmd(OP_LIST,   32'sd0,          32'sd0,          1'b0);
    queue_cmd(OP_REMOVE, 32'sd5,          32'sd0,          1'b0);
    queue_cmd(OP_INSERT, 32'sh8000_0000,  32'sh7FFF_FFFF,  1'b0);
    queue_cmd(OP_INSERT, 32'sh7FFF_FFFF,  32'sh8000_0000,  1'b0);
    queue_cmd(OP_INSERT, 32'sd0,          32'sd0,          1'b0);
    queue_cmd(OP_INSERT, 32'shFFFF_FFFF,  32'shFFFF_FFFF,  1'b0);
    queue_cmd(OP_INSERT, 32'sd1,          32'sh5555_5555,  1'b0);
    queue_cmd(OP_INSERT, 32'sd0,          32'sh1234_5678,  1'b0);
    queue_cmd(OP_LIST,   32'sd0,          32'sd0,          1'b0);
    queue_cmd(OpUnused,  32'sd1,          32'sd9,          1'b0);
    queue_cmd(OP_REMOVE, 32'sh7FFF_FFFF,  32'sd0,          1'b0);
    queue_cmd(OP_REMOVE, 32'sh8000_0000,  32'sd0,          1'b0);
    queue_cmd(OP_REMOVE, 32'sd7,          32'sd0,          1'b0);
    queue_cmd(OP_LIST,   32'sd0,          32'sd0,          1'b1);
    queue_cmd(OP_REMOVE, 32'sd0,          32'sd0,          1'b0);
    queue_cmd(OP_REMOVE, 32'shFFFF_FFFF,  32'sd0,          1'b0);
    queue_cmd(OP_REMOVE, 32'sd1,          32'sd0,          1'b0);
    queue_cmd(OP_LIST,   32'sd0,          32'sd0,          1'b0);
    queue_cmd(OP_INSERT, 32'sh7FFF_FFFE,  32'shAAAA_AAAA,  1'b0);
    queue_cmd(OP_LIST,   32'sd0,          32'sd0,          1'b0);

    // random: fill, fill, drain phases over a small key pool so the table runs full
    for (int unsigned i = 0; i < RandItems; i++) begin
      phase = (i / 70) % 3;
      r = $urandom_range(0, 99);
      if (phase != 2)
        op = (r < 78) ? OP_INSERT : (r < 88) ? OP_REMOVE : (r < 98) ? OP_LIST : OpUnused;
      else
        op = (r < 20) ? OP_INSERT : (r < 80) ? OP_REMOVE : (r < 97) ? OP_LIST : OpUnused;
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KeyPool - 1)]
                                       : $urandom;
      queue_cmd(op, k, $urandom, (i % 50) == 49);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("sorted_key_value_table_top verification clean");
    end else begin
      $display("sorted_key_value_table_top verification failed");
    end
    $finish;
  end

endmodule
